### hw/rtl/b64e_pkg.sv
// Shared types, constants and the symbol-to-ASCII mapping for the Base64 encoder.
// No dependencies.
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [6:0] CHAR_PAD   = 7'h3d;
    localparam logic [6:0] CHAR_PLUS  = 7'h2b;
    localparam logic [6:0] CHAR_SLASH = 7'h2f;
    localparam logic [6:0] CHAR_MINUS = 7'h2d;
    localparam logic [6:0] CHAR_UNDER = 7'h5f;
    localparam logic [6:0] CHAR_UPPER = 7'h41;
    localparam logic [6:0] CHAR_LOWER = 7'h61;
    localparam logic [6:0] CHAR_DIGIT = 7'h30;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_UNUSED = 2'd3;

    // One classified byte: up to four characters, index of the last one, end flag.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            final_flag;
    } t_entry;

    function automatic logic [6:0] map_symbol(input logic [5:0] sym, input logic url);
        logic [6:0] s7;
        logic [6:0] ch;
        s7 = {1'b0, sym};
        if (sym < 6'd26) begin
            ch = CHAR_UPPER + s7;
        end else if (sym < 6'd52) begin
            ch = CHAR_LOWER + s7 - 7'd26;
        end else if (sym < 6'd62) begin
            ch = CHAR_DIGIT + s7 - 7'd52;
        end else if (sym == 6'd62) begin
            ch = url ? CHAR_MINUS : CHAR_PLUS;
        end else begin
            ch = url ? CHAR_UNDER : CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

### hw/rtl/b64e_front.sv
// Front end: accepts bytes, tracks group position and leftover bits, builds queue entries.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_final_byte,
    output t_entry     o_entry
);

    logic       r_url;
    logic [1:0] r_pos;
    logic [3:0] r_carry;
    logic [1:0] n_pos;
    logic [3:0] n_carry;
    t_entry     n_entry;

    always_comb begin
        n_entry = '0;
        n_pos   = r_pos;
        n_carry = r_carry;
        unique case (r_pos)
            POS_SECOND: begin
                n_entry.chars[0] = map_symbol({r_carry[1:0], i_data_byte[7:4]}, r_url);
                n_carry = i_data_byte[3:0];
                n_pos   = POS_THIRD;
                if (i_is_final_byte) begin
                    n_entry.chars[1] = map_symbol({i_data_byte[3:0], 2'b00}, r_url);
                    n_entry.chars[2] = CHAR_PAD;
                    n_entry.last_idx = r_url ? 2'd1 : 2'd2;
                end
            end
            POS_THIRD: begin
                n_entry.chars[0] = map_symbol({r_carry, i_data_byte[7:6]}, r_url);
                n_entry.chars[1] = map_symbol(i_data_byte[5:0], r_url);
                n_entry.last_idx = 2'd1;
                n_carry = 4'd0;
                n_pos   = POS_FIRST;
            end
            POS_FIRST, POS_UNUSED: begin
                n_entry.chars[0] = map_symbol(i_data_byte[7:2], r_url);
                n_carry = {2'b00, i_data_byte[1:0]};
                n_pos   = POS_SECOND;
                if (i_is_final_byte) begin
                    n_entry.chars[1] = map_symbol({i_data_byte[1:0], 4'b0000}, r_url);
                    n_entry.chars[2] = CHAR_PAD;
                    n_entry.chars[3] = CHAR_PAD;
                    n_entry.last_idx = r_url ? 2'd1 : 2'd3;
                end
            end
            default: begin
                n_pos = POS_FIRST;
            end
        endcase
        n_entry.final_flag = i_is_final_byte;
        if (i_is_final_byte) begin
            n_pos   = POS_FIRST;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_url   <= 1'b0;
            r_pos   <= POS_FIRST;
            r_carry <= 4'd0;
        end else begin
            if (i_cfg_we) begin
                r_url <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_carry <= n_carry;
            end
        end
    end

    assign o_entry = n_entry;

endmodule

### hw/rtl/b64e_queue.sv
// Short entry queue between front and back ends.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wr_data,
    input  logic   i_rd,
    output t_entry o_rd_data,
    output logic   o_full,
    output logic   o_empty
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

### hw/rtl/b64e_back.sv
// Back end: steps through the characters of the head entry into the output register.
// Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  logic       i_head_valid,
    output logic       o_head_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [6:0] o_out_char,
    output logic       o_is_final_char
);

    logic       r_out_valid;
    logic [6:0] r_out_char;
    logic       r_out_final;
    logic [1:0] r_idx;
    logic       load;
    logic       at_last;

    assign load       = i_head_valid && (!r_out_valid || i_pop);
    assign at_last    = (r_idx == i_head.last_idx);
    assign o_head_pop = load && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char  <= i_head.chars[r_idx];
            r_out_final <= i_head.final_flag && at_last;
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_is_final_char = r_out_final;

endmodule

### hw/rtl/base64_stream_encoder_core.sv
// Base64 stream encoder, top level: front end, entry queue, back end.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
// An accepted byte's entry is written into the queue; the back end then loads its
// characters into the output register, one character per cycle while entries wait and the receiver pops,
// so a byte yields 1 or 2 characters and a final byte up to 4, per the entry's last index.
// Reset: synchronous, active low; clears queue, group position, leftover bits and mode.
module base64_stream_encoder_core import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_out_char,
    output logic       o_is_final_char
);

    t_entry front_entry;
    t_entry head_entry;
    logic   q_full;
    logic   q_empty;
    logic   head_pop;
    logic   accept;

    assign accept = push && !q_full;
    assign full   = q_full;

    b64e_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_is_final_byte (i_is_final_byte),
        .o_entry         (front_entry)
    );

    b64e_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (front_entry),
        .i_rd      (head_pop),
        .o_rd_data (head_entry),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    b64e_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_entry),
        .i_head_valid    (!q_empty),
        .o_head_pop      (head_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_char      (o_out_char),
        .o_is_final_char (o_is_final_char)
    );

endmodule

### hw/rtl/b64e_checker.sv
// Port-level checks for the Base64 encoder, bound to the top level.
// Depends on b64e_pkg and base64_stream_encoder_core.
module b64e_checker import b64e_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [6:0] o_out_char,
    input logic       o_is_final_char
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("outputs not idle after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_char) && $stable(o_is_final_char))
        else $error("stalled result changed");

    a_pad_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && o_out_char == CHAR_PAD && !o_is_final_char
        |=> !empty && o_out_char == CHAR_PAD && o_is_final_char)
        else $error("first padding not followed by final padding");

endmodule

bind base64_stream_encoder_core b64e_checker u_b64e_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_out_char      (o_out_char),
    .o_is_final_char (o_is_final_char)
);

### test/tb_top.sv
// Self-checking testbench for base64_stream_encoder_core: directed table, then random messages.
// Predicts every character and its end flag in-house; depends on b64e_pkg and the RTL only.
module tb_top import b64e_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STALL_LIMIT = 1000;
    localparam int    RAND_BYTES  = 88;
    localparam int    QUIET_AFTER = 70;
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_t;

    typedef struct {
        bit         mode;
        logic [7:0] b;
        bit         fin;
        string      known;
    } dir_row_t;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic       i_cfg_wdata     = 1'b0;
    logic       push            = 1'b0;
    logic       full;
    logic [7:0] i_data_byte     = 8'h00;
    logic       i_is_final_byte = 1'b0;
    logic       empty;
    logic       pop             = 1'b0;
    logic [6:0] o_out_char;
    logic       o_is_final_char;

    char_t      pending_chars[$];
    logic [1:0] enc_pos   = POS_FIRST;
    logic [3:0] enc_carry = 4'h0;
    bit         enc_url   = 1'b0;

    bit quiet        = 1'b0;
    int mismatches   = 0;
    int bytes_sent   = 0;
    int messages     = 0;
    int chars_seen   = 0;
    int mode_writes  = 0;
    int rx_stall     = 0;
    int stall_cycles = 0;

    dir_row_t dir_rows[20] = '{
        '{1'b0, 8'h00, 1'b1, "AA=="},
        '{1'b0, 8'hFF, 1'b1, "/w=="},
        '{1'b0, 8'hFF, 1'b0, "/"},
        '{1'b0, 8'hFF, 1'b0, "/"},
        '{1'b0, 8'hFF, 1'b1, "//"},
        '{1'b1, 8'hFF, 1'b0, "_"},
        '{1'b1, 8'hFF, 1'b0, "_"},
        '{1'b1, 8'hFF, 1'b1, "__"},
        '{1'b1, 8'hFB, 1'b1, "-w"},
        '{1'b0, 8'hFB, 1'b1, "+w=="},
        '{1'b0, 8'h00, 1'b0, "A"},
        '{1'b0, 8'h00, 1'b1, "AA="},
        '{1'b1, 8'hFF, 1'b0, "_"},
        '{1'b1, 8'hFF, 1'b1, "_8"},
        '{1'b0, 8'hFB, 1'b0, ""},
        '{1'b1, 8'hEF, 1'b1, ""},
        '{1'b0, 8'h4D, 1'b0, "T"},
        '{1'b0, 8'h61, 1'b0, "W"},
        '{1'b0, 8'h6E, 1'b1, "Fu"},
        '{1'b1, 8'h00, 1'b1, "AA"}
    };

    base64_stream_encoder_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_is_final_byte (i_is_final_byte),
        .empty           (empty),
        .pop             (pop),
        .o_out_char      (o_out_char),
        .o_is_final_char (o_is_final_char)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [6:0] sym_char(input logic [5:0] s, input bit url);
        byte c;
        c = B64_ALPHABET[s];
        if (url && s == 6'd62) begin
            return CHAR_MINUS;
        end else if (url && s == 6'd63) begin
            return CHAR_UNDER;
        end
        return c[6:0];
    endfunction

    // Advance the encoder state by one byte and queue the characters it produces.
    task automatic encode_byte(input logic [7:0] b, input bit fin, input string known);
        logic [6:0] chars[$];
        logic [1:0] pos;
        byte        k;
        char_t      ent;
        pos = (enc_pos == POS_UNUSED) ? POS_FIRST : enc_pos;
        case (pos)
            POS_FIRST: begin
                chars = {chars, sym_char(b[7:2], enc_url)};
                enc_carry = {2'b00, b[1:0]};
                enc_pos   = POS_SECOND;
                if (fin) begin
                    chars = {chars, sym_char({enc_carry[1:0], 4'h0}, enc_url)};
                    if (!enc_url) begin
                        chars = {chars, CHAR_PAD};
                        chars = {chars, CHAR_PAD};
                    end
                end
            end
            POS_SECOND: begin
                chars = {chars, sym_char({enc_carry[1:0], b[7:4]}, enc_url)};
                enc_carry = b[3:0];
                enc_pos   = POS_THIRD;
                if (fin) begin
                    chars = {chars, sym_char({enc_carry, 2'b00}, enc_url)};
                    if (!enc_url) begin
                        chars = {chars, CHAR_PAD};
                    end
                end
            end
            default: begin
                chars = {chars, sym_char({enc_carry, b[7:6]}, enc_url)};
                chars = {chars, sym_char(b[5:0], enc_url)};
                enc_carry = 4'h0;
                enc_pos   = POS_FIRST;
            end
        endcase
        if (fin) begin
            enc_carry = 4'h0;
            enc_pos   = POS_FIRST;
            messages++;
        end
        if (known.len() != 0) begin
            chars.delete();
            for (int i = 0; i < known.len(); i++) begin
                k = known[i];
                chars = {chars, k[6:0]};
            end
        end
        foreach (chars[i]) begin
            ent = '{chars[i], fin && (i == chars.size() - 1)};
            pending_chars = {pending_chars, ent};
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_mode(input bit m);
        push <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        enc_url  = m;
        mode_writes++;
    endtask

    task automatic send_byte(input logic [7:0] b, input bit fin, input string known);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= b;
        i_is_final_byte <= fin;
        do @(posedge i_clk); while (full);
        encode_byte(b, fin, known);
        bytes_sent++;
    endtask

    // Result side: check each transaction, then decide whether to stall.
    always @(posedge i_clk) begin
        char_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                chars_seen++;
                if (pending_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected char 0x%02h end=%0b",
                                            o_out_char, o_is_final_char));
                end else begin
                    want = pending_chars.pop_front();
                    if (o_out_char !== want.ch || o_is_final_char !== want.last) begin
                        note_mismatch($sformatf("char 0x%02h end=%0b, expected 0x%02h end=%0b",
                                                o_out_char, o_is_final_char, want.ch, want.last));
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rx_stall = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int         rand_bytes;
        int         len;
        logic [7:0] rb;
        bit         calm;
        rand_bytes = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].mode != enc_url) begin
                write_mode(dir_rows[r].mode);
            end
            send_byte(dir_rows[r].b, dir_rows[r].fin, dir_rows[r].known);
        end

        // Hold the sender until every character of the directed part is out.
        push <= 1'b0;
        wait_drained();

        while (rand_bytes < RAND_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                write_mode(1'($urandom_range(0, 1)));
            end
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
            calm = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < len; i++) begin
                if (i > 0 && $urandom_range(0, 15) == 0) begin
                    write_mode(!enc_url);
                end
                quiet = calm || (rand_bytes >= QUIET_AFTER);
                if ($urandom_range(0, 7) == 0) begin
                    rb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end else begin
                    rb = 8'($urandom);
                end
                send_byte(rb, i == len - 1, "");
                rand_bytes++;
            end
        end
        quiet = 1'b1;
        push <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Encoded %0d bytes in %0d messages into %0d checked characters,",
                 bytes_sent, messages, chars_seen);
        $display("across %0d alphabet mode writes with random stalls on both sides.",
                 mode_writes);
        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
